>>> hw/rtl/sparse_level_scheduler_assert.svh
// Assertion macros used by the sparse level scheduler back end.
`ifndef SPARSE_LEVEL_SCHEDULER_ASSERT_SVH
`define SPARSE_LEVEL_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define SLS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SLS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SLS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define SLS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

>>> hw/rtl/sls_pkg.sv
// Package: sizes, command codes and the command word of the level scheduler.
`default_nettype none

package sls_pkg;

  localparam int MAX_ROWS = 1024;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int LVL_W    = $clog2(MAX_ROWS);
  localparam int CNT_W    = $clog2(MAX_ROWS + 1);
  localparam int STG_W    = 11;
  localparam int FUNC_W   = 2;

  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  // Input function codes.
  localparam logic [FUNC_W-1:0] FUNC_ENTRY   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

  // Result kinds.
  localparam logic KIND_LEVEL = 1'b0;
  localparam logic KIND_STAGE = 1'b1;

  // Decoded command opcodes carried through the queue.
  typedef enum logic [1:0] {
    OP_ENTRY   = 2'd0,
    OP_MARK    = 2'd1,
    OP_READ    = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [ROW_W-1:0] column;
    logic             row_end;
    logic [STG_W-1:0] stage_index;
  } cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/sls_req_if.sv
// Interface: input transaction channel of the level scheduler.
`default_nettype none

interface sls_req_if
  import sls_pkg::*;
();

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ROW_W-1:0]  column;
  logic              has_entry;
  logic              row_end;
  logic [STG_W-1:0]  stage_index;

  modport source (output valid, func, column, has_entry, row_end, stage_index,
                  input ready);
  modport sink   (input valid, func, column, has_entry, row_end, stage_index,
                  output ready);

endinterface

`default_nettype wire

>>> hw/rtl/sls_rsp_if.sv
// Interface: result transaction channel of the level scheduler.
`default_nettype none

interface sls_rsp_if
  import sls_pkg::*;
();

  logic             valid;
  logic             ready;
  logic             kind;
  logic [ROW_W-1:0] row_index;
  logic [LVL_W-1:0] row_level;
  logic [LVL_W-1:0] max_level;
  logic [STG_W-1:0] stage_start;

  modport source (output valid, kind, row_index, row_level, max_level, stage_start,
                  input ready);
  modport sink   (input valid, kind, row_index, row_level, max_level, stage_start,
                  output ready);

endinterface

`default_nettype wire

>>> hw/rtl/sls_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sls_front.sv
// Front end: accept input transactions, decode them and drop those with no effect.
`default_nettype none

module sls_front
  import sls_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  sls_req_if.sink   req,
  output logic      cmd_valid,
  input  wire logic cmd_ready,
  output cmd_t      cmd
);

  logic hold_valid;
  cmd_t hold_cmd;
  cmd_t dec_cmd;
  logic dec_keep;
  logic accept;

  // Decode the incoming transaction into a queue command.
  always_comb begin
    dec_cmd.op          = OP_ENTRY;
    dec_cmd.column      = req.column;
    dec_cmd.row_end     = req.row_end;
    dec_cmd.stage_index = req.stage_index;
    dec_keep            = 1'b0;
    unique case (req.func)
      FUNC_ENTRY: begin
        dec_cmd.op = req.has_entry ? OP_ENTRY : OP_MARK;
        // A marker that does not close the row does nothing.
        dec_keep   = req.has_entry || req.row_end;
      end
      FUNC_READ: begin
        dec_cmd.op = OP_READ;
        dec_keep   = 1'b1;
      end
      FUNC_RESTART: begin
        dec_cmd.op = OP_RESTART;
        dec_keep   = 1'b1;
      end
      default: begin
        dec_keep = 1'b0;
      end
    endcase
  end

  assign req.ready = !hold_valid || cmd_ready;
  assign accept    = req.valid && req.ready;

  // Hold one decoded command until the queue takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= dec_keep;
    end else if (cmd_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_cmd <= dec_cmd;
    end
  end

  assign cmd_valid = hold_valid;
  assign cmd       = hold_cmd;

endmodule

`default_nettype wire

>>> hw/rtl/sls_cmd_fifo.sv
// Short command queue between the front end and the back end.
`default_nettype none

module sls_cmd_fifo
  import sls_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire cmd_t push_cmd,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output cmd_t      pop_cmd
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_cmd    = slots[rd_ptr];

  // Advance pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // Store pushed commands.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sls_back.sv
// Back end: run queued commands against the level and histogram memories.
`default_nettype none

`include "sparse_level_scheduler_assert.svh"

module sls_back
  import sls_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  output logic      q_ready,
  input  wire cmd_t q_cmd,
  sls_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENT,
    S_CLOSE,
    S_SUM,
    S_SUM_LAST
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] rows_done;
  logic [LVL_W-1:0] current_best;
  logic [LVL_W-1:0] highest_level;
  logic [LVL_W-1:0] close_lvl;
  logic             row_end_hold;
  logic [ROW_W-1:0] idx;
  logic [ROW_W-1:0] target_m1;
  logic             pend;
  logic [CNT_W-1:0] acc;

  logic             res_valid;
  logic             res_kind;
  logic [ROW_W-1:0] res_row;
  logic [LVL_W-1:0] res_level;
  logic [LVL_W-1:0] res_max;
  logic [STG_W-1:0] res_start;

  logic             lvl_wr_en;
  logic             lvl_rd_en;
  logic [LVL_W-1:0] lvl_rdata;
  logic             cnt_wr_en;
  logic             cnt_rd_en;
  logic [ROW_W-1:0] cnt_rd_addr;
  logic [CNT_W-1:0] cnt_rdata;
  logic [CNT_W-1:0] cnt_wdata;

  logic             slot_free;
  logic             start;
  logic             full;
  logic             dep_hit;
  logic             above;
  logic             imm_read;
  logic [LVL_W-1:0] cand;
  logic [LVL_W-1:0] best_new;
  logic             fresh;
  logic [LVL_W-1:0] highest_new;
  logic [CNT_W-1:0] sum_last;

  // Start a command only when the result slot is free or draining.
  assign slot_free = !res_valid || rsp.ready;
  assign start     = (state == S_IDLE) && q_valid && slot_free;
  assign q_ready   = start;

  assign full    = (rows_done == CNT_W'(MAX_ROWS));
  assign dep_hit = (q_cmd.op == OP_ENTRY) && ({1'b0, q_cmd.column} < rows_done);
  assign above   = (q_cmd.stage_index > STG_W'(highest_level));

  // Flag a stage read that is answered in its start cycle.
  assign imm_read = start && (q_cmd.op == OP_READ) &&
                    (above || (q_cmd.stage_index == '0));

  // Candidate level from a looked-up column.
  assign cand     = lvl_rdata + LVL_W'(1);
  assign best_new = (cand > current_best) ? cand : current_best;

  // A level above the highest seen, or any level of an empty matrix, has no count yet.
  assign fresh       = (rows_done == '0) || (close_lvl > highest_level);
  assign cnt_wdata   = (fresh ? CNT_W'(0) : cnt_rdata) + CNT_W'(1);
  assign highest_new = (close_lvl > highest_level) ? close_lvl : highest_level;
  assign sum_last    = acc + cnt_rdata;

  // Memory port control.
  always_comb begin
    lvl_rd_en   = 1'b0;
    cnt_rd_en   = 1'b0;
    cnt_rd_addr = idx;
    lvl_wr_en   = 1'b0;
    cnt_wr_en   = 1'b0;
    unique case (state)
      S_IDLE: begin
        lvl_rd_en   = start && !full && dep_hit &&
                      ((q_cmd.op == OP_ENTRY) || (q_cmd.op == OP_MARK));
        cnt_rd_en   = start && !full && !dep_hit && q_cmd.row_end &&
                      ((q_cmd.op == OP_ENTRY) || (q_cmd.op == OP_MARK));
        cnt_rd_addr = current_best;
      end
      S_ENT: begin
        cnt_rd_en   = row_end_hold;
        cnt_rd_addr = best_new;
      end
      S_CLOSE: begin
        lvl_wr_en = 1'b1;
        cnt_wr_en = 1'b1;
      end
      S_SUM: begin
        cnt_rd_en   = 1'b1;
        cnt_rd_addr = idx;
      end
      S_SUM_LAST: begin
        cnt_rd_en = 1'b0;
      end
      default: begin
        cnt_rd_en = 1'b0;
      end
    endcase
  end

  sls_ram #(
    .WIDTH (LVL_W),
    .DEPTH (MAX_ROWS)
  ) u_lvl_ram (
    .clk     (clk),
    .wr_en   (lvl_wr_en),
    .wr_addr (rows_done[ROW_W-1:0]),
    .wr_data (close_lvl),
    .rd_en   (lvl_rd_en),
    .rd_addr (q_cmd.column),
    .rd_data (lvl_rdata)
  );

  sls_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_ROWS)
  ) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cnt_wr_en),
    .wr_addr (close_lvl),
    .wr_data (cnt_wdata),
    .rd_en   (cnt_rd_en),
    .rd_addr (cnt_rd_addr),
    .rd_data (cnt_rdata)
  );

  // Sequencer, matrix state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rows_done     <= '0;
      current_best  <= '0;
      highest_level <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (res_valid && rsp.ready && !imm_read) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            row_end_hold <= q_cmd.row_end;
            unique case (q_cmd.op)
              OP_ENTRY, OP_MARK: begin
                if (!full) begin
                  if (dep_hit) begin
                    state <= S_ENT;
                  end else if (q_cmd.row_end) begin
                    close_lvl <= current_best;
                    state     <= S_CLOSE;
                  end
                end
              end
              OP_READ: begin
                if (above || (q_cmd.stage_index == '0)) begin
                  res_valid <= 1'b1;
                  res_kind  <= KIND_STAGE;
                  res_row   <= '0;
                  res_level <= '0;
                  res_max   <= highest_level;
                  res_start <= above ? STG_W'(rows_done) : STG_W'(0);
                end else begin
                  idx       <= '0;
                  target_m1 <= q_cmd.stage_index[ROW_W-1:0] - ROW_W'(1);
                  pend      <= 1'b0;
                  acc       <= '0;
                  state     <= S_SUM;
                end
              end
              OP_RESTART: begin
                rows_done     <= '0;
                current_best  <= '0;
                highest_level <= '0;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_ENT: begin
          current_best <= best_new;
          if (row_end_hold) begin
            close_lvl <= best_new;
            state     <= S_CLOSE;
          end else begin
            state <= S_IDLE;
          end
        end
        S_CLOSE: begin
          res_valid     <= 1'b1;
          res_kind      <= KIND_LEVEL;
          res_row       <= rows_done[ROW_W-1:0];
          res_level     <= close_lvl;
          res_max       <= highest_new;
          res_start     <= '0;
          highest_level <= highest_new;
          rows_done     <= rows_done + CNT_W'(1);
          current_best  <= '0;
          state         <= S_IDLE;
        end
        S_SUM: begin
          acc  <= acc + (pend ? cnt_rdata : CNT_W'(0));
          pend <= 1'b1;
          idx  <= idx + ROW_W'(1);
          if (idx == target_m1) begin
            state <= S_SUM_LAST;
          end
        end
        S_SUM_LAST: begin
          res_valid <= 1'b1;
          res_kind  <= KIND_STAGE;
          res_row   <= '0;
          res_level <= '0;
          res_max   <= highest_level;
          res_start <= STG_W'(sum_last);
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid       = res_valid;
  assign rsp.kind        = res_kind;
  assign rsp.row_index   = res_row;
  assign rsp.row_level   = res_level;
  assign rsp.max_level   = res_max;
  assign rsp.stage_start = res_start;

  // Result slot is never overwritten while a result is still pending.
  `SLS_ASSERT_IMP(a_slot_free, clk, rst, (state == S_CLOSE) || (state == S_SUM_LAST), !res_valid || rsp.ready, "result overwritten before it was taken")
  // Row count never passes capacity.
  `SLS_ASSERT_IMP(a_cap, clk, rst, 1'b1, rows_done <= CNT_W'(MAX_ROWS), "row count beyond capacity")
  // Every level stays below the number of closed rows.
  `SLS_ASSERT_IMP(a_lvl_bound, clk, rst, rows_done != '0, CNT_W'(highest_level) < rows_done, "highest level not below row count")
  // A row close advances the row count by one.
  `SLS_ASSERT_NXT(a_close_adv, clk, rst, state == S_CLOSE, rows_done == $past(rows_done) + CNT_W'(1), "row close did not advance row count")

endmodule

`default_nettype wire

>>> hw/rtl/sparse_level_scheduler.sv
// Top level: level scheduler for a sparse matrix streamed row by row.
//
//   channel  role    handshake     contents
//   req      sink    valid/ready   func, column, has_entry, row_end, stage_index
//   rsp      source  valid/ready   kind, row_index, row_level, max_level, stage_start
//
// Back end per command: an entry or marker is handled in S_IDLE, an entry below
// the row adds a level-memory lookup (S_ENT), and a row close adds a histogram
// read-modify-write (S_CLOSE). A stage read above the highest level or at level 0
// is answered from S_IDLE; otherwise it walks S_SUM, one histogram word read per
// cycle, then S_SUM_LAST. The front register and four-deep command queue come first.
// Reset is synchronous and needs no clearing pass: histogram words above the
// highest level are treated as zero. A stalled result holds the back end; the
// queue and the front register then fill up and req.ready drops.
`default_nettype none

module sparse_level_scheduler
  import sls_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  sls_req_if.sink   req,
  sls_rsp_if.source rsp
);

  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  sls_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  sls_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  sls_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_cmd   (q_cmd),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire

>>> test/sparse_level_scheduler_tb.sv
// Testbench for the sparse level scheduler: directed, back-pressure, capacity and random tests.
`timescale 1ns / 1ps

module sparse_level_scheduler_tb
  import sls_pkg::*;
;

  // Function code that the block ignores.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ROW_W-1:0]  column;
    logic              has_entry;
    logic              row_end;
    logic [STG_W-1:0]  stage_index;
  } sched_cmd_t;

  typedef struct packed {
    logic             kind;
    logic [ROW_W-1:0] row_index;
    logic [LVL_W-1:0] row_level;
    logic [LVL_W-1:0] max_level;
    logic [STG_W-1:0] stage_start;
  } sched_result_t;

  logic clk;
  logic rst;

  sls_req_if req_ch ();
  sls_rsp_if rsp_ch ();

  sparse_level_scheduler u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Scoreboard state.
  sched_result_t due_results [$];
  bit            failed;
  bit            idle_on;
  int            sink_hold;
  int            items_sent;

  // Shadow of the scheduler state.
  logic [LVL_W-1:0] lvl_of_row  [MAX_ROWS];
  logic [CNT_W-1:0] rows_at_lvl [MAX_ROWS];
  logic [CNT_W-1:0] rows_closed;
  logic [LVL_W-1:0] open_level;
  logic [LVL_W-1:0] peak_level;

  // Generate the clock.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Clear the per-matrix part of the shadow state.
  function automatic void clear_matrix_state();
    for (int i = 0; i < MAX_ROWS; i++) rows_at_lvl[i] = '0;
    rows_closed = '0;
    open_level  = '0;
    peak_level  = '0;
  endfunction

  // Advance the shadow state by one accepted command and queue its result, if it gives one.
  function automatic void compute_schedule(input sched_cmd_t cmd);
    sched_result_t    res;
    logic [LVL_W:0]   cand;
    logic [CNT_W-1:0] acc;
    res = '0;
    case (cmd.func)
      FUNC_ENTRY: begin
        if (rows_closed < CNT_W'(MAX_ROWS)) begin
          // Raise the open row's level for an entry below the row.
          if (cmd.has_entry && ({1'b0, cmd.column} < rows_closed)) begin
            cand = {1'b0, lvl_of_row[cmd.column]} + (LVL_W+1)'(1);
            if (cand > {1'b0, open_level}) open_level = cand[LVL_W-1:0];
          end
          // Close the row: store, count and report its level.
          if (cmd.row_end) begin
            lvl_of_row[rows_closed[ROW_W-1:0]] = open_level;
            rows_at_lvl[open_level] = rows_at_lvl[open_level] + CNT_W'(1);
            if (open_level > peak_level) peak_level = open_level;
            res.kind      = KIND_LEVEL;
            res.row_index = rows_closed[ROW_W-1:0];
            res.row_level = open_level;
            res.max_level = peak_level;
            rows_closed   = rows_closed + CNT_W'(1);
            open_level    = '0;
            due_results.push_back(res);
          end
        end
      end
      FUNC_READ: begin
        // Sum the histogram below the asked level.
        acc = '0;
        if (cmd.stage_index > STG_W'(peak_level)) begin
          acc = rows_closed;
        end else begin
          for (int i = 0; i < int'(cmd.stage_index) && i < MAX_ROWS; i++)
            acc = acc + rows_at_lvl[i];
        end
        res.kind        = KIND_STAGE;
        res.max_level   = peak_level;
        res.stage_start = acc;
        due_results.push_back(res);
      end
      FUNC_RESTART: clear_matrix_state();
      default: ;
    endcase
  endfunction

  // Drive one transaction on the request channel and wait for its handshake.
  task automatic send_item(input sched_cmd_t cmd);
    int gap;
    gap = idle_on ? $urandom_range(0, 14) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.func        <= cmd.func;
    req_ch.column      <= cmd.column;
    req_ch.has_entry   <= cmd.has_entry;
    req_ch.row_end     <= cmd.row_end;
    req_ch.stage_index <= cmd.stage_index;
    do @(posedge clk); while (!req_ch.ready);
    compute_schedule(cmd);
    if (cmd.func != FUNC_UNUSED) items_sent++;
  endtask

  task automatic push_entry(input int column, input bit has_entry, input bit row_end);
    sched_cmd_t cmd;
    cmd.func        = FUNC_ENTRY;
    cmd.column      = column[ROW_W-1:0];
    cmd.has_entry   = has_entry;
    cmd.row_end     = row_end;
    cmd.stage_index = STG_W'($urandom_range(0, 1024));
    send_item(cmd);
  endtask

  task automatic push_read(input int stage_index);
    sched_cmd_t cmd;
    cmd.func        = FUNC_READ;
    cmd.column      = ROW_W'($urandom_range(0, 1023));
    cmd.has_entry   = 1'($urandom_range(0, 1));
    cmd.row_end     = 1'($urandom_range(0, 1));
    cmd.stage_index = stage_index[STG_W-1:0];
    send_item(cmd);
  endtask

  task automatic push_restart();
    sched_cmd_t cmd;
    cmd.func        = FUNC_RESTART;
    cmd.column      = ROW_W'($urandom_range(0, 1023));
    cmd.has_entry   = 1'($urandom_range(0, 1));
    cmd.row_end     = 1'($urandom_range(0, 1));
    cmd.stage_index = STG_W'($urandom_range(0, 1024));
    send_item(cmd);
  endtask

  task automatic push_noise();
    sched_cmd_t cmd;
    cmd.func        = FUNC_UNUSED;
    cmd.column      = ROW_W'($urandom_range(0, 1023));
    cmd.has_entry   = 1'($urandom_range(0, 1));
    cmd.row_end     = 1'($urandom_range(0, 1));
    cmd.stage_index = STG_W'($urandom_range(0, 1024));
    send_item(cmd);
  endtask

  // Pick a stage level, mostly near the levels in use.
  function automatic int pick_stage();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(0, int'(peak_level) + 2);
    if (r < 9) return $urandom_range(0, 1024);
    return 1024;
  endfunction

  // Empty rows, diagonal and upper entries, unused code and stage reads.
  task automatic test_directed();
    idle_on = 1'b1;
    push_restart();
    push_entry(0, 1'b0, 1'b1);
    push_entry(0, 1'b1, 1'b1);
    push_entry(1023, 1'b1, 1'b0);
    push_entry(7, 1'b0, 1'b0);
    push_entry(2, 1'b1, 1'b0);
    push_entry(1, 1'b1, 1'b0);
    push_entry(0, 1'b1, 1'b1);
    push_entry(1, 1'b0, 1'b1);
    push_noise();
    push_read(0);
    push_read(1);
    push_read(2);
    push_read(3);
    push_read(1024);
    push_entry(3, 1'b1, 1'b0);
    push_entry(2, 1'b1, 1'b1);
    push_read(3);
    push_restart();
    push_read(0);
    push_read(1);
    push_entry(0, 1'b1, 1'b1);
    push_read(1);
  endtask

  // Hold off the result side for a long stretch while rows keep coming.
  task automatic test_result_backpressure();
    idle_on   = 1'b0;
    sink_hold = 400;
    for (int i = 0; i < 12; i++) begin
      push_entry(0, 1'b1, 1'b1);
      push_read(pick_stage());
    end
    idle_on = 1'b1;
  endtask

  // Fill the matrix with a full dependence chain, then overflow it.
  task automatic test_row_capacity();
    idle_on = 1'b0;
    push_restart();
    push_entry(0, 1'b0, 1'b1);
    for (int r = 1; r < MAX_ROWS; r++) push_entry(r - 1, 1'b1, 1'b1);
    idle_on = 1'b1;
    push_entry(5, 1'b1, 1'b0);
    push_entry(1023, 1'b1, 1'b1);
    push_entry(0, 1'b0, 1'b1);
    push_read(1023);
    push_read(1024);
    push_read(0);
    push_read(512);
    push_read(1);
    push_restart();
    push_read(0);
  endtask

  // Random matrices, with stray restarts, unused codes and stage reads.
  task automatic test_random_matrices(input int item_goal);
    int start_count;
    int rows_goal;
    int n_ent;
    int pick;
    bit close_by_marker;
    start_count = items_sent;
    while (items_sent - start_count < item_goal) begin
      idle_on = ($urandom_range(0, 3) != 0);
      push_restart();
      rows_goal = $urandom_range(4, 60);
      for (int r = 0; r < rows_goal && items_sent - start_count < item_goal; r++) begin
        n_ent = $urandom_range(0, 4);
        close_by_marker = (n_ent == 0) || ($urandom_range(0, 3) == 0);
        for (int k = 0; k < n_ent; k++) begin
          pick = $urandom_range(0, 99);
          if ($urandom_range(0, 199) == 0) push_restart();
          if (pick < 10) begin
            push_entry($urandom_range(0, 1023), 1'b0, !close_by_marker && k == n_ent - 1);
          end else if (pick < 22 || rows_closed == 0) begin
            push_entry($urandom_range(int'(rows_closed), 1023), 1'b1,
                       !close_by_marker && k == n_ent - 1);
          end else begin
            push_entry($urandom_range(0, int'(rows_closed) - 1), 1'b1,
                       !close_by_marker && k == n_ent - 1);
          end
        end
        if (close_by_marker) push_entry($urandom_range(0, 1023), 1'b0, 1'b1);
        if ($urandom_range(0, 6) == 0) push_read(pick_stage());
        if ($urandom_range(0, 39) == 0) push_noise();
      end
    end
    idle_on = 1'b1;
  endtask

  // Accept results, stalling at random after each transaction while idle_on is set and while sink_hold runs down.
  initial begin : result_sink
    int   stall_left;
    logic took;
    stall_left   = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      took = rsp_ch.valid && rsp_ch.ready;
      if (took && idle_on) stall_left = $urandom_range(0, 14);
      @(negedge clk);
      if (sink_hold > 0) begin
        sink_hold--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      failed = 1'b1;
    end
  endfunction

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin : result_check
    sched_result_t exp_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d stage_start %0d",
                 $time, rsp_ch.kind, rsp_ch.stage_start);
        failed = 1'b1;
      end else begin
        exp_r = due_results.pop_front();
        check_field("kind", 32'(exp_r.kind), 32'(rsp_ch.kind));
        check_field("row_index", 32'(exp_r.row_index), 32'(rsp_ch.row_index));
        check_field("row_level", 32'(exp_r.row_level), 32'(rsp_ch.row_level));
        check_field("max_level", 32'(exp_r.max_level), 32'(rsp_ch.max_level));
        check_field("stage_start", 32'(exp_r.stage_start), 32'(rsp_ch.stage_start));
      end
    end
  end

  // Stop a hung run.
  initial begin : watchdog
    #2_000_000;
    $display("sparse_level_scheduler regression: fail");
    $finish;
  end

  initial begin : stimulus
    int wait_cycles;
    failed     = 1'b0;
    idle_on    = 1'b1;
    sink_hold  = 0;
    items_sent = 0;
    for (int i = 0; i < MAX_ROWS; i++) lvl_of_row[i] = '0;
    clear_matrix_state();
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.func        = FUNC_ENTRY;
    req_ch.column      = '0;
    req_ch.has_entry   = 1'b0;
    req_ch.row_end     = 1'b0;
    req_ch.stage_index = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_result_backpressure();
    test_row_capacity();
    test_random_matrices(100);

    @(negedge clk);
    req_ch.valid <= 1'b0;

    // Drain outstanding results, then watch for strays.
    wait_cycles = 0;
    while (due_results.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (1100) @(posedge clk);
    if (due_results.size() != 0) begin
      $display("%0t: results missing: expected %0d more, actual 0", $time, due_results.size());
      failed = 1'b1;
    end
    if (!failed) $display("sparse_level_scheduler regression: pass");
    else $display("sparse_level_scheduler regression: fail");
    $finish;
  end

endmodule
